// ===== sv/multichannel_spike_threshold_detector_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spike threshold detector
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SPIKE_THRESHOLD_DETECTOR_CORE_ASSERT_SVH
`define MULTICHANNEL_SPIKE_THRESHOLD_DETECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MSTD_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define MSTD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSTD_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`define MSTD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/mstd_pkg.sv =====
// ----------------------------------------------------------------------------
// mstd_pkg
// Types and constants shared by the spike threshold detector files.
// ----------------------------------------------------------------------------
`default_nettype none

package mstd_pkg;

  // Field widths of a transaction.
  localparam int CHANNEL_W = 6;
  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_DETECT_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_TIME   = 1'b1;

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Threshold of a channel that has never been loaded.
  localparam logic signed [SAMPLE_W-1:0] THRESH_RESET = -16'sd2000;

  // Result queue sizing.
  localparam int RESULT_DEPTH = 4;
  localparam int PTR_W        = $clog2(RESULT_DEPTH);
  localparam int COUNT_W      = PTR_W + 1;
  localparam int OCC_W        = COUNT_W + 1;

  // Detection tests.
  typedef enum logic [1:0] {
    MODE_NEG  = 2'd0,
    MODE_POS  = 2'd1,
    MODE_NEO  = 2'd2,
    MODE_MEAN = 2'd3
  } mode_t;

  // One result as it is queued.
  typedef struct packed {
    logic                 spike;
    logic [CHANNEL_W-1:0] spike_channel;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/mstd_item_if.sv =====
// ----------------------------------------------------------------------------
// mstd_item_if
// Input channel: one sample or one threshold load per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstd_item_if;

  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [mstd_pkg::CHANNEL_W-1:0]        channel;
  logic signed [mstd_pkg::SAMPLE_W-1:0]  sample;
  logic [mstd_pkg::TIME_W-1:0]           timestamp;
  logic signed [mstd_pkg::SAMPLE_W-1:0]  threshold;
  logic signed [mstd_pkg::SAMPLE_W-1:0]  mean;

  modport source (
    output valid, operation, channel, sample, timestamp, threshold, mean,
    input  ready
  );

  modport sink (
    input  valid, operation, channel, sample, timestamp, threshold, mean,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/mstd_result_if.sv =====
// ----------------------------------------------------------------------------
// mstd_result_if
// Output channel: one detection result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstd_result_if;

  logic                           valid;
  logic                           ready;
  logic                           spike;
  logic [mstd_pkg::CHANNEL_W-1:0] spike_channel;

  modport source (
    output valid, spike, spike_channel,
    input  ready
  );

  modport sink (
    input  valid, spike, spike_channel,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/mstd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// mstd_result_fifo
// Small result queue that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mstd_result_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire mstd_pkg::result_t            push_data,
  output logic [mstd_pkg::COUNT_W-1:0]      count,
  mstd_result_if.source                     results
);

  mstd_pkg::result_t                  entries [mstd_pkg::RESULT_DEPTH];
  logic [mstd_pkg::PTR_W-1:0]         wr_ptr;
  logic [mstd_pkg::PTR_W-1:0]         rd_ptr;
  logic                               pop;
  mstd_pkg::result_t                  head;

  // A transaction leaves whenever the head is taken.
  assign pop  = results.valid && results.ready;
  assign head = entries[rd_ptr];

  assign results.valid         = (count != '0);
  assign results.spike         = head.spike;
  assign results.spike_channel = head.spike_channel;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/multichannel_spike_threshold_detector_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_spike_threshold_detector_core
// Per-channel threshold, NEO and mean-deviation spike detection with a
// refractory window, holding all channel state in two synchronous memories.
// ----------------------------------------------------------------------------
//
//   Channel   Kind            Payload
//   items     valid/ready in  operation, channel, sample, timestamp,
//                             threshold, mean
//   results   valid/ready out spike, spike_channel
//   cfg_*     write only      cfg_index selects detect_mode or dead_time
//
// One transaction is accepted every cycle while items is not held off (see below);
// its result passes the memory read with the multipliers, the energy compare
// with the write-back, and the result queue register before it is offered,
// with forwarding between them.
// Reset clears the per-entry valid bits; no clearing pass.
// A stalled output fills a four-entry result queue; items is held off only
// when the queue and the two stages in flight would overfill it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_spike_threshold_detector_core_assert.svh"

module multichannel_spike_threshold_detector_core #(
  parameter int CHANNELS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mstd_item_if.sink                                items,
  mstd_result_if.source                            results,
  input  wire logic                                cfg_write,
  input  wire logic [mstd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mstd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW     = mstd_pkg::SAMPLE_W;
  localparam int TW     = mstd_pkg::TIME_W;
  localparam int CW     = mstd_pkg::CHANNEL_W;

  // Configuration registers.
  mstd_pkg::mode_t   detect_mode;
  logic [TW-1:0]     dead_time;

  // Channel memories: {threshold, mean} and {last trigger, prev, prev prev}.
  logic [2*SW-1:0]       cfg_mem  [CHANNELS];
  logic [TW+2*SW-1:0]    hist_mem [CHANNELS];
  logic [CHANNELS-1:0]   cfg_valid;
  logic [CHANNELS-1:0]   hist_valid;
  logic [2*SW-1:0]       cfg_rd;
  logic [TW+2*SW-1:0]    hist_rd;
  logic                  cfg_rd_ok;
  logic                  hist_rd_ok;

  // Acceptance and read address.
  logic                  accept;
  logic [8:0]            chan9;
  logic [7:0]            chan8;
  logic                  in_range;
  logic [ADDR_W-1:0]     rd_addr;

  // First stage.
  logic                  s1_v;
  logic                  s1_op;
  logic [CW-1:0]         s1_ch;
  logic [ADDR_W-1:0]     s1_addr;
  logic                  s1_in_range;
  logic signed [SW-1:0]  s1_x;
  logic [TW-1:0]         s1_ts;
  logic signed [SW-1:0]  s1_thr_in;
  logic signed [SW-1:0]  s1_mean_in;

  // Forwarded channel state seen by the first stage.
  logic signed [SW-1:0]  thr_fwd;
  logic signed [SW-1:0]  mean_fwd;
  logic signed [SW-1:0]  prev_fwd;
  logic signed [SW-1:0]  pprev_fwd;
  logic [TW-1:0]         last_fwd;
  logic signed [16:0]    dev;
  logic signed [17:0]    dev18;
  logic signed [17:0]    abs_dev;
  logic signed [17:0]    thr18;
  logic                  hit_cmp;
  logic signed [31:0]    prod_pp;
  logic signed [31:0]    prod_px;

  // Second stage.
  logic                  s2_v;
  logic                  s2_op;
  logic [CW-1:0]         s2_ch;
  logic [ADDR_W-1:0]     s2_addr;
  logic                  s2_in_range;
  logic signed [SW-1:0]  s2_x;
  logic signed [SW-1:0]  s2_prev;
  logic [TW-1:0]         s2_ts;
  logic signed [SW-1:0]  s2_thr_in;
  logic signed [SW-1:0]  s2_mean_in;
  logic signed [SW-1:0]  s2_thr;
  logic [TW-1:0]         s2_last;
  logic [TW-1:0]         s2_limit;
  logic                  s2_hit_cmp;
  logic signed [31:0]    s2_pp;
  logic signed [31:0]    s2_px;

  // Second stage decision.
  logic signed [32:0]    pp33;
  logic signed [32:0]    px33;
  logic signed [32:0]    energy;
  logic signed [32:0]    thr33;
  logic                  hit;
  logic [TW-1:0]         last_eff;
  logic                  fire;
  logic                  cfg_we;
  logic                  hist_we;
  logic [TW-1:0]         last_new;

  // Last write, kept in registers for forwarding.
  logic                  wb_cfg_v;
  logic                  wb_hist_v;
  logic [ADDR_W-1:0]     wb_addr;
  logic signed [SW-1:0]  wb_thr;
  logic signed [SW-1:0]  wb_mean;
  logic [TW-1:0]         wb_last;
  logic signed [SW-1:0]  wb_prev;
  logic signed [SW-1:0]  wb_pprev;

  // Result queue.
  mstd_pkg::result_t              push_data;
  logic [mstd_pkg::COUNT_W-1:0]   fifo_count;
  logic [mstd_pkg::OCC_W-1:0]     occupancy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_mode <= mstd_pkg::MODE_NEG;
      dead_time   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mstd_pkg::REG_DETECT_MODE: detect_mode <= mstd_pkg::mode_t'(cfg_data[1:0]);
        mstd_pkg::REG_DEAD_TIME:   dead_time   <= cfg_data[TW-1:0];
        default:                   dead_time   <= dead_time;
      endcase
    end
  end

  // Input acceptance, held off only when the result queue could overfill.
  assign occupancy = mstd_pkg::OCC_W'(fifo_count) + mstd_pkg::OCC_W'(s1_v)
                   + mstd_pkg::OCC_W'(s2_v);
  assign items.ready = (occupancy < mstd_pkg::OCC_W'(mstd_pkg::RESULT_DEPTH));
  assign accept      = items.valid && items.ready;

  assign chan9    = 9'(items.channel);
  assign chan8    = 8'(items.channel);
  assign in_range = (chan9 < 9'(CHANNELS));
  assign rd_addr  = in_range ? chan8[ADDR_W-1:0] : '0;

  // First stage capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_op       <= items.operation;
    s1_ch       <= items.channel;
    s1_addr     <= rd_addr;
    s1_in_range <= in_range;
    s1_x        <= items.sample;
    s1_ts       <= items.timestamp;
    s1_thr_in   <= items.threshold;
    s1_mean_in  <= items.mean;
  end

  // Memory reads, registered, and write-back from the second stage.
  always_ff @(posedge clk) begin
    cfg_rd     <= cfg_mem[rd_addr];
    hist_rd    <= hist_mem[rd_addr];
    cfg_rd_ok  <= cfg_valid[rd_addr];
    hist_rd_ok <= hist_valid[rd_addr];
    if (cfg_we) begin
      cfg_mem[s2_addr] <= {s2_thr_in, s2_mean_in};
    end
    if (hist_we) begin
      hist_mem[s2_addr] <= {last_new, s2_x, s2_prev};
    end
  end

  // An entry that was never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_valid  <= '0;
      hist_valid <= '0;
    end else begin
      if (cfg_we) begin
        cfg_valid[s2_addr] <= 1'b1;
      end
      if (hist_we) begin
        hist_valid[s2_addr] <= 1'b1;
      end
    end
  end

  // Forwarding: the second stage is newest, then the last write, then memory.
  always_comb begin
    thr_fwd  = cfg_rd_ok ? cfg_rd[2*SW-1:SW] : mstd_pkg::THRESH_RESET;
    mean_fwd = cfg_rd_ok ? cfg_rd[SW-1:0] : '0;
    if (s2_v && (s2_op == mstd_pkg::OP_WRITE) && s2_in_range && (s2_addr == s1_addr)) begin
      thr_fwd  = s2_thr_in;
      mean_fwd = s2_mean_in;
    end else if (wb_cfg_v && (wb_addr == s1_addr)) begin
      thr_fwd  = wb_thr;
      mean_fwd = wb_mean;
    end
  end

  always_comb begin
    last_fwd  = hist_rd_ok ? hist_rd[TW+2*SW-1:2*SW] : '0;
    prev_fwd  = hist_rd_ok ? hist_rd[2*SW-1:SW] : '0;
    pprev_fwd = hist_rd_ok ? hist_rd[SW-1:0] : '0;
    if (wb_hist_v && (wb_addr == s1_addr)) begin
      last_fwd  = wb_last;
      prev_fwd  = wb_prev;
      pprev_fwd = wb_pprev;
    end
    // The trigger time of the second stage is resolved there, once the item reaches it.
    if (s2_v && (s2_op == mstd_pkg::OP_SAMPLE) && s2_in_range && (s2_addr == s1_addr)) begin
      prev_fwd  = s2_x;
      pprev_fwd = s2_prev;
    end
  end

  // Threshold and mean-deviation tests.
  assign dev     = {s1_x[SW-1], s1_x} - {mean_fwd[SW-1], mean_fwd};
  assign dev18   = {dev[16], dev};
  assign abs_dev = dev18[17] ? -dev18 : dev18;
  assign thr18   = {{2{thr_fwd[SW-1]}}, thr_fwd};

  always_comb begin
    hit_cmp = 1'b0;
    case (detect_mode)
      mstd_pkg::MODE_NEG:  hit_cmp = (s1_x < thr_fwd);
      mstd_pkg::MODE_POS:  hit_cmp = (s1_x > thr_fwd);
      mstd_pkg::MODE_MEAN: hit_cmp = (abs_dev > thr18);
      default:             hit_cmp = 1'b0;
    endcase
  end

  // NEO products, registered before the difference.
  assign prod_pp = prev_fwd * prev_fwd;
  assign prod_px = pprev_fwd * s1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_op       <= s1_op;
    s2_ch       <= s1_ch;
    s2_addr     <= s1_addr;
    s2_in_range <= s1_in_range;
    s2_x        <= s1_x;
    s2_prev     <= prev_fwd;
    s2_ts       <= s1_ts;
    s2_thr_in   <= s1_thr_in;
    s2_mean_in  <= s1_mean_in;
    s2_thr      <= thr_fwd;
    s2_last     <= last_fwd;
    s2_limit    <= s1_ts - dead_time;
    s2_hit_cmp  <= hit_cmp;
    s2_pp       <= prod_pp;
    s2_px       <= prod_px;
  end

  // Energy test and refractory check.
  assign pp33   = {s2_pp[31], s2_pp};
  assign px33   = {s2_px[31], s2_px};
  assign energy = pp33 - px33;
  assign thr33  = {{17{s2_thr[SW-1]}}, s2_thr};
  assign hit    = (detect_mode == mstd_pkg::MODE_NEO) ? (energy > thr33) : s2_hit_cmp;

  assign last_eff = (wb_hist_v && (wb_addr == s2_addr)) ? wb_last : s2_last;
  assign hist_we  = s2_v && (s2_op == mstd_pkg::OP_SAMPLE) && s2_in_range;
  assign cfg_we   = s2_v && (s2_op == mstd_pkg::OP_WRITE) && s2_in_range;
  assign fire     = hist_we && hit && (last_eff < s2_limit);
  assign last_new = fire ? s2_ts : last_eff;

  // Keep the last write for the stages behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_cfg_v  <= 1'b0;
      wb_hist_v <= 1'b0;
    end else begin
      wb_cfg_v  <= cfg_we;
      wb_hist_v <= hist_we;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr  <= s2_addr;
    wb_thr   <= s2_thr_in;
    wb_mean  <= s2_mean_in;
    wb_last  <= last_new;
    wb_prev  <= s2_x;
    wb_pprev <= s2_prev;
  end

  // Every transaction yields one result.
  assign push_data.spike         = fire;
  assign push_data.spike_channel = s2_ch;

  mstd_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_v),
    .push_data (push_data),
    .count     (fifo_count),
    .results   (results)
  );

  // Checks on the pipeline and the result queue.
  `MSTD_ASSERT_IMPLIES(a_occupancy, clk, rst, s1_v || s2_v, (occupancy <= mstd_pkg::OCC_W'(mstd_pkg::RESULT_DEPTH)), "result queue overcommitted")
  `MSTD_ASSERT_IMPLIES(a_push_room, clk, rst, s2_v, ((fifo_count < mstd_pkg::COUNT_W'(mstd_pkg::RESULT_DEPTH)) || results.ready), "result pushed into a full queue")
  `MSTD_ASSERT_NEXT(a_fire_stamp, clk, rst, fire, (wb_hist_v && (wb_last == $past(s2_ts))), "trigger time not recorded")
  `MSTD_ASSERT_IMPLIES(a_spike_range, clk, rst, results.valid && results.spike, (9'(results.spike_channel) < 9'(CHANNELS)), "spike on a channel out of range")

endmodule

`default_nettype wire

// ===== dv/spike_detect_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spike_detect_checker
// Watches the item, result and configuration ports of the spike detector,
// keeps its own copy of the per-channel state, predicts one result per
// accepted transaction and compares each result field by field.
// ----------------------------------------------------------------------------

module spike_detect_checker import mstd_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  mstd_item_if                   items,
  mstd_result_if                 results,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  // Shadow configuration.
  mode_t             test_sel;
  logic [TIME_W-1:0] refractory;

  // Shadow per-channel state.
  logic signed [SAMPLE_W-1:0] thr_mem   [CHANNELS];
  logic signed [SAMPLE_W-1:0] mean_mem  [CHANNELS];
  logic signed [SAMPLE_W-1:0] last_x    [CHANNELS];
  logic signed [SAMPLE_W-1:0] older_x   [CHANNELS];
  logic [TIME_W-1:0]          fired_at  [CHANNELS];

  result_t spikes_due[$];
  int      fail_total = 0;

  // Applies one transaction to the shadow state and returns its result.
  function automatic result_t detect_spike(
    input logic                       op,
    input logic [CHANNEL_W-1:0]       ch,
    input logic signed [SAMPLE_W-1:0] x,
    input logic [TIME_W-1:0]          now,
    input logic signed [SAMPLE_W-1:0] thr_in,
    input logic signed [SAMPLE_W-1:0] mean_in
  );
    result_t           r;
    logic              hit;
    logic              armed;
    logic [TIME_W-1:0] window_end;
    logic signed [63:0] xs, p, pp, thr, level;
    r.spike = 1'b0;
    r.spike_channel = ch;
    if (ch < CHANNELS) begin
      if (op == OP_WRITE) begin
        thr_mem[ch]  = thr_in;
        mean_mem[ch] = mean_in;
      end else begin
        xs  = x;
        p   = last_x[ch];
        pp  = older_x[ch];
        thr = thr_mem[ch];
        // The channel is armed once its last trigger lies before the window.
        window_end = now - refractory;
        armed = fired_at[ch] < window_end;
        case (test_sel)
          MODE_NEG: begin
            hit = xs < thr;
          end
          MODE_POS: begin
            hit = xs > thr;
          end
          MODE_NEO: begin
            level = p * p - pp * xs;
            hit = level > thr;
          end
          default: begin
            level = xs - 64'(mean_mem[ch]);
            if (level < 0) begin
              level = -level;
            end
            hit = level > thr;
          end
        endcase
        if (hit && armed) begin
          fired_at[ch] = now;
          r.spike = 1'b1;
        end
        // The history moves on every sample, fired or not.
        older_x[ch] = last_x[ch];
        last_x[ch]  = x;
      end
    end
    return r;
  endfunction

  // Results are checked before new expectations are queued in the same cycle.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      test_sel   = MODE_NEG;
      refractory = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        thr_mem[c]  = THRESH_RESET;
        mean_mem[c] = '0;
        last_x[c]   = '0;
        older_x[c]  = '0;
        fired_at[c] = '0;
      end
      spikes_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DETECT_MODE: begin
            test_sel = mode_t'(cfg_data[1:0]);
          end
          REG_DEAD_TIME: begin
            refractory = cfg_data[TIME_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (results.valid && results.ready) begin
        if (spikes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual spike %0b channel %0d",
                   $time, results.spike, results.spike_channel);
          fail_total++;
        end else begin
          want = spikes_due.pop_front();
          if (results.spike !== want.spike) begin
            $display("%0t: spike on channel %0d, expected %0b, actual %0b",
                     $time, want.spike_channel, want.spike, results.spike);
            fail_total++;
          end
          if (results.spike_channel !== want.spike_channel) begin
            $display("%0t: spike_channel, expected %0d, actual %0d",
                     $time, want.spike_channel, results.spike_channel);
            fail_total++;
          end
        end
      end
      if (items.valid && items.ready) begin
        spikes_due.push_back(detect_spike(items.operation, items.channel, items.sample,
                                          items.timestamp, items.threshold, items.mean));
      end
    end
    mismatches  <= fail_total;
    outstanding <= spikes_due.size();
  end

endmodule

// ===== dv/multichannel_spike_threshold_detector_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_spike_threshold_detector_core_tb
// Drives directed and random samples and threshold loads into the spike
// detector under several detection tests and refractory settings, with
// random gaps on both sides; a checker beside the block judges the results.
// ----------------------------------------------------------------------------

module multichannel_spike_threshold_detector_core_tb;

  import mstd_pkg::*;

  localparam int CHANNELS     = 64;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic [TIME_W-1:0]          TIME_MAX   = 32'hFFFF_FFFF;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     outstanding;

  // Running time base and idling controls for the random part.
  logic [TIME_W-1:0] tick;
  bit                src_steady = 1'b0;
  bit                snk_steady = 1'b0;

  mstd_item_if   items_ch ();
  mstd_result_if results_ch ();

  multichannel_spike_threshold_detector_core #(
    .CHANNELS (CHANNELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spike_detect_checker #(
    .CHANNELS (CHANNELS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .items       (items_ch),
    .results     (results_ch),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: stalls at random unless held steady.
  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      results_ch.ready <= snk_steady || ($urandom_range(99) >= 19);
    end
  end

  // Offers one transaction, possibly after a random gap, and waits for it to be taken.
  task automatic send_item(
    input logic                       op,
    input logic [CHANNEL_W-1:0]       ch,
    input logic signed [SAMPLE_W-1:0] x,
    input logic [TIME_W-1:0]          ts,
    input logic signed [SAMPLE_W-1:0] thr,
    input logic signed [SAMPLE_W-1:0] mn
  );
    while (!src_steady && $urandom_range(99) < 19) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid     <= 1'b1;
    items_ch.operation <= op;
    items_ch.channel   <= ch;
    items_ch.sample    <= x;
    items_ch.timestamp <= ts;
    items_ch.threshold <= thr;
    items_ch.mean      <= mn;
    do @(posedge clk); while (!items_ch.ready);
  endtask

  // Holds the input off until every result is back, then lets the pipeline empty.
  task automatic settle();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Writes both registers while the block is idle.
  task automatic configure(input mode_t mode, input logic [TIME_W-1:0] dead);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_DETECT_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_DEAD_TIME;
    cfg_data  <= CFG_DATA_W'(dead);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random transaction: mostly samples on a busy few channels or anywhere.
  task automatic send_random();
    logic                       op;
    logic [CHANNEL_W-1:0]       ch;
    logic signed [SAMPLE_W-1:0] x, thr, mn;
    int                         pick;
    op = ($urandom_range(99) < 10) ? OP_WRITE : OP_SAMPLE;
    ch = $urandom_range(1) ? CHANNEL_W'($urandom_range(3)) : CHANNEL_W'($urandom);
    // Background noise, large excursions of either sign, or anything at all.
    pick = $urandom_range(99);
    if (pick < 50) begin
      x = SAMPLE_W'(int'($urandom_range(600)) - 300);
    end else if (pick < 75) begin
      x = SAMPLE_W'(int'($urandom_range(32767, 2000)));
      if ($urandom_range(1)) begin
        x = -x;
      end
    end else begin
      x = SAMPLE_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 30) begin
      thr = SAMPLE_W'($urandom);
    end else if (pick < 70) begin
      thr = SAMPLE_W'(-int'($urandom_range(3000, 100)));
    end else begin
      thr = SAMPLE_W'(int'($urandom_range(3000, 100)));
    end
    mn = $urandom_range(1) ? SAMPLE_W'(int'($urandom_range(400)) - 200) : SAMPLE_W'($urandom);
    // Time mostly creeps forward; now and then it jumps or sits just short of the wrap.
    pick = $urandom_range(99);
    if (pick < 3) begin
      tick = $urandom;
    end else if (pick < 4) begin
      tick = TIME_MAX - TIME_W'($urandom_range(40));
    end else begin
      tick = tick + TIME_W'($urandom_range(12));
    end
    send_item(op, ch, x, tick, thr, mn);
  endtask

  // Stimulus and verdict.
  initial begin
    mode_t             mode;
    logic [TIME_W-1:0] dead;
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= REG_DETECT_MODE;
    cfg_data            <= '0;
    items_ch.valid      <= 1'b0;
    items_ch.operation  <= OP_SAMPLE;
    items_ch.channel    <= '0;
    items_ch.sample     <= '0;
    items_ch.timestamp  <= '0;
    items_ch.threshold  <= '0;
    items_ch.mean       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: below threshold, no refractory time.
    send_item(OP_SAMPLE, 6'd0,  SAMPLE_MIN, 32'd1, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd0,  SAMPLE_MIN, 32'd1, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd63, SAMPLE_MAX, 32'd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd63, -16'sd2000, 32'd5, 16'sd0, 16'sd0);
    send_item(OP_WRITE,  6'd5,  SAMPLE_MIN, TIME_MAX, SAMPLE_MAX, SAMPLE_MIN);
    send_item(OP_WRITE,  6'd63, SAMPLE_MAX, 32'd0, SAMPLE_MIN, SAMPLE_MAX);
    send_item(OP_SAMPLE, 6'd5,  16'sd32766, 32'd100, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd63, SAMPLE_MIN, TIME_MAX, 16'sd0, 16'sd0);

    // Above threshold with the longest refractory time: the window closes at the wrap.
    configure(MODE_POS, TIME_MAX);
    send_item(OP_SAMPLE, 6'd1,  SAMPLE_MAX, TIME_MAX, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd1,  SAMPLE_MAX, 32'd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd1,  SAMPLE_MAX, 32'd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd63, -16'sd32767, 32'd10, 16'sd0, 16'sd0);

    // Energy test: the largest history products.
    configure(MODE_NEO, '0);
    send_item(OP_SAMPLE, 6'd2,  SAMPLE_MIN, 32'd20, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd2,  SAMPLE_MIN, 32'd21, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd2,  SAMPLE_MAX, 32'd22, 16'sd0, 16'sd0);
    send_item(OP_WRITE,  6'd3,  16'sd0, 32'd0, SAMPLE_MAX, 16'sd0);
    send_item(OP_SAMPLE, 6'd3,  16'sd0, 32'd30, 16'sd0, 16'sd0);

    // Deviation from the mean, at its widest and at the equality boundary.
    configure(MODE_MEAN, 32'd3);
    send_item(OP_SAMPLE, 6'd5,  SAMPLE_MAX, 32'd200, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd5,  SAMPLE_MIN, 32'd201, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd63, SAMPLE_MAX, 32'd300, 16'sd0, 16'sd0);
    send_item(OP_WRITE,  6'd4,  16'sd0, 32'd0, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd4,  16'sd0, 32'd400, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 6'd4,  16'sd1, 32'd401, 16'sd0, 16'sd0);

    // Random phases, each under its own settings; one runs with no idling at all.
    tick = 32'd1000;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          mode = MODE_NEG;
          dead = '0;
        end
        1: begin
          mode = MODE_POS;
          dead = 32'd20;
        end
        2: begin
          mode = MODE_NEO;
          dead = TIME_MAX;
        end
        3: begin
          mode = MODE_MEAN;
          dead = 32'd7;
        end
        default: begin
          mode = mode_t'($urandom_range(3));
          case ($urandom_range(3))
            0: dead = '0;
            1: dead = TIME_W'($urandom_range(60, 1));
            2: dead = TIME_MAX;
            default: dead = $urandom;
          endcase
        end
      endcase
      configure(mode, dead);
      src_steady = (p == 4);
      snk_steady = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
      end
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mstd_pkg.sv
sv/mstd_item_if.sv
sv/mstd_result_if.sv
sv/mstd_result_fifo.sv
sv/multichannel_spike_threshold_detector_core.sv
dv/spike_detect_checker.sv
dv/multichannel_spike_threshold_detector_core_tb.sv
